// File: rtl/chkv_pkg.sv
// Shared constants, types and status codes of the chained hash key-value table.
package chkv_pkg;

    localparam int BUCKETS  = 64;
    localparam int ENTRIES  = 256;
    localparam int BUCKET_W = $clog2(BUCKETS);
    localparam int IDX_W    = $clog2(ENTRIES);
    localparam int USED_W   = $clog2(ENTRIES + 1);
    localparam int KEY_W    = 32;
    localparam int VAL_W    = 32;
    localparam int STAT_W   = 3;

    typedef enum logic [STAT_W-1:0] {
        ST_INSERTED = 3'd0,
        ST_UPDATED  = 3'd1,
        ST_FULL     = 3'd2,
        ST_FOUND    = 3'd3,
        ST_NOTFOUND = 3'd4
    } status_t;

    // controller -> datapath
    typedef struct packed {
        logic load;           // capture request, read bucket head
        logic rd_entry_head;  // read entry at bucket head
        logic rd_entry_next;  // read entry at next link
        logic finish;         // resolve request, commit writes, post result
        logic hit;            // key found (qualifies finish)
    } ctrl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic head_valid;     // bucket has a chain
        logic key_match;      // entry just read holds the key
        logic next_valid;     // entry just read has a successor
    } dp_status_t;

endpackage

// File: rtl/chkv_ram.sv
// Generic single-write, single-read RAM with registered read data.
module chkv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/chkv_ctrl.sv
// Request sequencer: head read, chain walk, finish.
module chkv_ctrl
    import chkv_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  dp_status_t stat,
    output ctrl_cmd_t  cmd,
    output logic       busy
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_HEAD = 3'b010,
        S_WALK = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_HEAD;
                end
            end
            S_HEAD:
            begin
                if (stat.head_valid)
                begin
                    cmd.rd_entry_head = 1'b1;
                    state_next        = S_WALK;
                end
                else
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_WALK:
            begin
                if (stat.key_match)
                begin
                    cmd.finish = 1'b1;
                    cmd.hit    = 1'b1;
                    state_next = S_IDLE;
                end
                else if (stat.next_valid)
                begin
                    cmd.rd_entry_next = 1'b1;
                end
                else
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

// File: rtl/chkv_dp.sv
// Datapath: request registers, bucket heads, entry pool and result register.
module chkv_dp
    import chkv_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  ctrl_cmd_t         cmd,
    output dp_status_t        stat,
    input  logic              action,
    input  logic [KEY_W-1:0]  key,
    input  logic [VAL_W-1:0]  value,
    output logic              done,
    output logic [STAT_W-1:0] status,
    output logic [VAL_W-1:0]  stored_value
);

    // request
    logic              action_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [VAL_W-1:0]  value_reg;
    logic [IDX_W-1:0]  cur_idx_reg;
    logic [IDX_W-1:0]  cur_idx_next;

    // table control state
    logic [BUCKETS-1:0] head_vld_reg;
    logic [USED_W-1:0]  used_reg;

    // result
    logic              done_reg;
    logic [STAT_W-1:0] status_reg;
    logic [STAT_W-1:0] status_next;
    logic [VAL_W-1:0]  result_reg;
    logic [VAL_W-1:0]  result_next;

    logic [BUCKET_W-1:0] bkt;
    logic [IDX_W-1:0]    head_rdata;
    logic [KEY_W-1:0]    key_rdata;
    logic [VAL_W-1:0]    val_rdata;
    logic [IDX_W:0]      nxt_rdata;
    logic                entry_re;
    logic [IDX_W-1:0]    entry_raddr;
    logic                full;
    logic                do_insert;
    logic                do_update;
    logic                val_we;
    logic [IDX_W-1:0]    val_waddr;

    assign bkt  = key_reg[BUCKET_W-1:0];
    assign full = (used_reg == USED_W'(ENTRIES));

    assign entry_re     = cmd.rd_entry_head | cmd.rd_entry_next;
    assign entry_raddr  = cmd.rd_entry_head ? head_rdata : nxt_rdata[IDX_W-1:0];
    assign cur_idx_next = entry_re ? entry_raddr : cur_idx_reg;

    assign stat.head_valid = head_vld_reg[bkt];
    assign stat.key_match  = (key_rdata == key_reg);
    assign stat.next_valid = nxt_rdata[IDX_W];

    always_comb
    begin
        do_insert   = 1'b0;
        do_update   = 1'b0;
        status_next = status_reg;
        result_next = result_reg;
        priority if (action_reg && cmd.hit)
        begin
            status_next = ST_FOUND;
            result_next = val_rdata;
        end
        else if (action_reg)
        begin
            status_next = ST_NOTFOUND;
            result_next = '0;
        end
        else if (cmd.hit)
        begin
            do_update   = cmd.finish;
            status_next = ST_UPDATED;
            result_next = value_reg;
        end
        else if (full)
        begin
            status_next = ST_FULL;
            result_next = '0;
        end
        else
        begin
            do_insert   = cmd.finish;
            status_next = ST_INSERTED;
            result_next = value_reg;
        end
    end

    assign val_we    = do_insert | do_update;
    assign val_waddr = do_update ? cur_idx_reg : used_reg[IDX_W-1:0];

    chkv_ram #(.WIDTH(IDX_W), .DEPTH(BUCKETS)) u_head_ram (
        .clk   (clk),
        .we    (do_insert),
        .waddr (bkt),
        .wdata (used_reg[IDX_W-1:0]),
        .re    (cmd.load),
        .raddr (key[BUCKET_W-1:0]),
        .rdata (head_rdata)
    );

    chkv_ram #(.WIDTH(KEY_W), .DEPTH(ENTRIES)) u_key_ram (
        .clk   (clk),
        .we    (do_insert),
        .waddr (used_reg[IDX_W-1:0]),
        .wdata (key_reg),
        .re    (entry_re),
        .raddr (entry_raddr),
        .rdata (key_rdata)
    );

    chkv_ram #(.WIDTH(VAL_W), .DEPTH(ENTRIES)) u_val_ram (
        .clk   (clk),
        .we    (val_we),
        .waddr (val_waddr),
        .wdata (value_reg),
        .re    (entry_re),
        .raddr (entry_raddr),
        .rdata (val_rdata)
    );

    // link field: {valid, index}
    chkv_ram #(.WIDTH(IDX_W + 1), .DEPTH(ENTRIES)) u_next_ram (
        .clk   (clk),
        .we    (do_insert),
        .waddr (used_reg[IDX_W-1:0]),
        .wdata ({head_vld_reg[bkt], head_rdata}),
        .re    (entry_re),
        .raddr (entry_raddr),
        .rdata (nxt_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_vld_reg <= '0;
            used_reg     <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.finish;
            if (do_insert)
            begin
                head_vld_reg[bkt] <= 1'b1;
                used_reg          <= used_reg + USED_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            action_reg <= action;
            key_reg    <= key;
            value_reg  <= value;
        end
        cur_idx_reg <= cur_idx_next;
        if (cmd.finish)
        begin
            status_reg <= status_next;
            result_reg <= result_next;
        end
    end

    assign done         = done_reg;
    assign status       = status_reg;
    assign stored_value = result_reg;

endmodule

// File: rtl/chained_hash_key_value_table.sv
// Top level of the chained hash key-value table.
//
// A request is transferred when start is high and busy is low. It is an add
// (action 0) or a lookup (action 1) of a 32-bit key; the bucket is the low
// six key bits (64 buckets) and the pool holds 256 entries. Each request
// gives exactly one result, shown on status/stored_value for the single
// cycle in which done is high; the receiver cannot stall it, so capture it
// then. From transfer to done a request passes the bucket head read, the
// reads of the chain entries (none for an empty bucket, otherwise up to the
// matching entry, or the whole chain on a miss) and the result register:
// one entry RAM read per cycle walks the chain. busy drops in the cycle
// done rises, so the next request may be transferred alongside the result.
// Reset empties the table at once through per-bucket valid flops; no
// clearing pass is needed. Nothing is ever freed: once 256 distinct keys
// are stored, adds of new keys return table full.
module chained_hash_key_value_table
    import chkv_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              action,
    input  logic [KEY_W-1:0]  key,
    input  logic [VAL_W-1:0]  value,
    output logic              done,
    output logic [STAT_W-1:0] status,
    output logic [VAL_W-1:0]  stored_value
);

    ctrl_cmd_t  cmd;
    dp_status_t stat;

    // sequencer: one state per phase of the walk
    chkv_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    // storage, compare and result register
    chkv_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .action       (action),
        .key          (key),
        .value        (value),
        .done         (done),
        .status       (status),
        .stored_value (stored_value)
    );

endmodule

// File: rtl/chkv_checker.sv
// Port-level assertions for the chained hash key-value table, with bind.
module chkv_checker
    import chkv_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic              done,
    input logic [STAT_W-1:0] status,
    input logic [VAL_W-1:0]  stored_value
);

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("transfer not followed by busy");

    a_fall_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy ended without a result");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result without a request in flight");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (status == ST_INSERTED || status == ST_UPDATED || status == ST_FULL
                  || status == ST_FOUND || status == ST_NOTFOUND))
        else $error("bad status code");

    a_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == ST_FULL || status == ST_NOTFOUND)) |-> (stored_value == '0))
        else $error("nonzero value on miss or full");

endmodule

bind chained_hash_key_value_table chkv_checker u_chkv_checker (.*);
